/* src/sdf_pkg.sv */
// Shared types and constants for the sync word frame deframer.
package sdf_pkg;

   localparam int WORDS_PER_FRAME = 8;
   localparam int STORE_DEPTH     = 8;
   localparam int SLOT_W          = $clog2(STORE_DEPTH);
   localparam int COUNT_W         = 4;
   localparam int BYTE_W          = 8;
   localparam int WORD_W          = 16;

   localparam logic [BYTE_W-1:0] SYNC_RESET = 8'hFF;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [WORD_W-1:0] word_type;
   typedef word_type [STORE_DEPTH-1:0] frame_type;

   typedef enum logic [2:0] {
      PH_HUNT1    = 3'd0,
      PH_HUNT2    = 3'd1,
      PH_FIRST_HI = 3'd2,
      PH_LO       = 3'd3,
      PH_HI       = 3'd4
   } phase_type;

   // staged input transaction
   typedef struct packed {
      logic     valid;
      byte_type data;
   } rx_xact_type;

endpackage

/* src/sync_word_frame_deframer.sv */
// Top level of the sync word frame deframer.
//
// Usage:
//   req_*  : one received byte per transaction (req_rx_byte), valid/ready.
//   rsp_*  : one transaction per completed frame, carrying the eight words
//            rsp_word_0 .. rsp_word_7 in received order, valid/ready.
//   csr_*  : write-only sync byte register (csr_sync_byte), always ready.
//            Write it only while no byte is in flight.
// A frame is two sync bytes followed by eight words, high byte first.
// A taken byte is held in the input register and parsed from there; a frame
// result is registered as its last byte is parsed. Throughput: one byte per
// cycle while no frame waits, set by the input and the single result register.
// Reset: sync byte returns to 0xFF, parser goes back to hunting for sync,
// no transaction pending on either channel.
// Stall: while a result waits on rsp_ready, bytes that complete no frame
// are still taken; a byte that completes a frame waits in the input
// register, and req_ready drops once that register cannot drain.
module sync_word_frame_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_word_0,
   output logic [15:0] rsp_word_1,
   output logic [15:0] rsp_word_2,
   output logic [15:0] rsp_word_3,
   output logic [15:0] rsp_word_4,
   output logic [15:0] rsp_word_5,
   output logic [15:0] rsp_word_6,
   output logic [15:0] rsp_word_7,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_sync_byte
);

   sdf_pkg::rx_xact_type rx;
   sdf_pkg::byte_type    sync_ff, sync_in;
   sdf_pkg::frame_type   frame;
   sdf_pkg::frame_type   rsp_frame;
   logic                 emit;
   logic                 space;
   logic                 fire;

   assign csr_ready = 1'b1;
   assign sync_in   = (csr_valid && csr_ready) ? csr_sync_byte : sync_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff <= sdf_pkg::SYNC_RESET;
      end else begin
         sync_ff <= sync_in;
      end
   end

   assign fire = rx.valid && (!emit || space);

   sdf_in_stage u_in (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .take        (fire),
      .rx          (rx)
   );

   sdf_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .rx        (rx),
      .sync_byte (sync_ff),
      .emit      (emit),
      .frame     (frame)
   );

   sdf_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (fire && emit),
      .frame     (frame),
      .space     (space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_frame (rsp_frame)
   );

   assign rsp_word_0 = rsp_frame[0];
   assign rsp_word_1 = rsp_frame[1];
   assign rsp_word_2 = rsp_frame[2];
   assign rsp_word_3 = rsp_frame[3];
   assign rsp_word_4 = rsp_frame[4];
   assign rsp_word_5 = rsp_frame[5];
   assign rsp_word_6 = rsp_frame[6];
   assign rsp_word_7 = rsp_frame[7];

   // a completed frame always shows up as a pending result
   a_emit_to_rsp: assert property (@(posedge clock) disable iff (reset)
      fire && emit |=> rsp_valid)
      else $error("completed frame did not reach the result register");

   // a waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !(fire && emit))
      else $error("pending result overwritten");

   // an accepted byte is held in the input register
   a_in_capture: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rx.valid)
      else $error("accepted byte lost at input register");

endmodule

/* src/sdf_in_stage.sv */
// Input register for received byte transactions.
module sdf_in_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  sdf_pkg::byte_type   req_rx_byte,
   input  logic                take,
   output sdf_pkg::rx_xact_type rx
);

   logic             valid_ff, valid_in;
   sdf_pkg::byte_type data_ff, data_in;

   assign req_ready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (take) begin
         valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
         data_in  = req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rx.valid = valid_ff;
   assign rx.data  = data_ff;

endmodule

/* src/sdf_parser.sv */
// Frame parser: sync hunt state machine, word counter and word store.
module sdf_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  sdf_pkg::rx_xact_type rx,
   input  sdf_pkg::byte_type    sync_byte,
   output logic                 emit,
   output sdf_pkg::frame_type   frame
);

   sdf_pkg::phase_type              phase_ff, phase_in;
   logic [sdf_pkg::COUNT_W-1:0]     count_ff, count_in;
   sdf_pkg::byte_type               hi_ff, hi_in;
   sdf_pkg::frame_type              store_ff, store_in;
   logic                            is_sync;
   logic [sdf_pkg::COUNT_W:0]       count_inc;
   logic [sdf_pkg::SLOT_W-1:0]      slot;

   assign is_sync   = (rx.data == sync_byte);
   assign count_inc = {1'b0, count_ff} + 1'b1;
   assign slot      = count_ff[sdf_pkg::SLOT_W-1:0];
   assign emit      = (phase_ff == sdf_pkg::PH_LO) &&
                      (count_inc >= (sdf_pkg::COUNT_W+1)'(sdf_pkg::WORDS_PER_FRAME));

   // next state
   always_comb begin
      phase_in = phase_ff;
      if (fire) begin
         case (phase_ff)
            sdf_pkg::PH_HUNT1: begin
               if (is_sync) phase_in = sdf_pkg::PH_HUNT2;
            end
            sdf_pkg::PH_HUNT2: begin
               phase_in = is_sync ? sdf_pkg::PH_FIRST_HI : sdf_pkg::PH_HUNT1;
            end
            sdf_pkg::PH_FIRST_HI: begin
               if (!is_sync) phase_in = sdf_pkg::PH_LO;
            end
            sdf_pkg::PH_LO: begin
               phase_in = emit ? sdf_pkg::PH_HUNT1 : sdf_pkg::PH_HI;
            end
            sdf_pkg::PH_HI: begin
               phase_in = is_sync ? sdf_pkg::PH_HUNT2 : sdf_pkg::PH_LO;
            end
            default: begin
               phase_in = sdf_pkg::PH_HUNT1;
            end
         endcase
      end
   end

   // datapath updates
   always_comb begin
      count_in = count_ff;
      hi_in    = hi_ff;
      store_in = store_ff;
      if (fire) begin
         case (phase_ff)
            sdf_pkg::PH_FIRST_HI: begin
               count_in = '0;
               hi_in    = rx.data;
            end
            sdf_pkg::PH_LO: begin
               store_in[slot] = {hi_ff, rx.data};
               count_in       = count_inc[sdf_pkg::COUNT_W-1:0];
            end
            sdf_pkg::PH_HI: begin
               hi_in = rx.data;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   always_comb begin
      for (int j = 0; j < sdf_pkg::STORE_DEPTH; j++) begin
         frame[j] = (j < sdf_pkg::WORDS_PER_FRAME) ? store_in[j] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sdf_pkg::PH_HUNT1;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      hi_ff    <= hi_in;
      store_ff <= store_in;
   end

endmodule

/* src/sdf_out_stage.sv */
// Result register holding one completed frame until taken.
module sdf_out_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  sdf_pkg::frame_type frame,
   output logic               space,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output sdf_pkg::frame_type rsp_frame
);

   logic               valid_ff, valid_in;
   sdf_pkg::frame_type frame_ff, frame_in;

   assign space = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = load || (valid_ff && !rsp_ready);
      frame_in = load ? frame : frame_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_frame = frame_ff;

endmodule

/* bench/tb.sv */
// Self-checking testbench for the sync word frame deframer.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT  = 5000;
   localparam int PHASE_BYTES  = 170;
   localparam int PHASES       = 8;
   localparam int DRAIN_CYCLES = 4;

   typedef enum {GAP_NONE, GAP_SEND, GAP_RECV, GAP_BOTH} gap_mode_type;

   // Tracks the parser and holds the frames still owed by the block.
   class frame_tracker;
      sdf_pkg::byte_type               sync;
      sdf_pkg::phase_type              phase;
      logic [sdf_pkg::COUNT_W-1:0]     count;
      sdf_pkg::word_type               store [sdf_pkg::STORE_DEPTH];
      sdf_pkg::frame_type              pending_frames [$];
      int                              errors;
      int                              frames_seen;
      int                              bytes_seen;

      function void clear();
         sync  = sdf_pkg::SYNC_RESET;
         phase = sdf_pkg::PH_HUNT1;
         count = '0;
         foreach (store[j]) store[j] = '0;
      endfunction

      function void set_sync(sdf_pkg::byte_type v);
         sync = v;
      endfunction

      function int pending();
         return pending_frames.size();
      endfunction

      function void take_byte(sdf_pkg::byte_type b);
         logic               hit;
         sdf_pkg::frame_type f;
         hit = (b == sync);
         bytes_seen++;
         case (phase)
            sdf_pkg::PH_HUNT1: begin
               if (hit) phase = sdf_pkg::PH_HUNT2;
            end
            sdf_pkg::PH_HUNT2: begin
               phase = hit ? sdf_pkg::PH_FIRST_HI : sdf_pkg::PH_HUNT1;
            end
            sdf_pkg::PH_FIRST_HI: begin
               count = '0;
               if (!hit) begin
                  store[0] = {b, 8'h00};
                  phase    = sdf_pkg::PH_LO;
               end
            end
            sdf_pkg::PH_LO: begin
               store[count[sdf_pkg::SLOT_W-1:0]] =
                  store[count[sdf_pkg::SLOT_W-1:0]] | {8'h00, b};
               count = count + 1'b1;
               if (count >= sdf_pkg::WORDS_PER_FRAME) begin
                  for (int j = 0; j < sdf_pkg::STORE_DEPTH; j++)
                     f[j] = (j < sdf_pkg::WORDS_PER_FRAME) ? store[j] : '0;
                  pending_frames.push_back(f);
                  phase = sdf_pkg::PH_HUNT1;
               end else begin
                  phase = sdf_pkg::PH_HI;
               end
            end
            sdf_pkg::PH_HI: begin
               if (hit) begin
                  phase = sdf_pkg::PH_HUNT2;
               end else begin
                  store[count[sdf_pkg::SLOT_W-1:0]] = {b, 8'h00};
                  phase = sdf_pkg::PH_LO;
               end
            end
            default: begin
               phase = sdf_pkg::PH_HUNT1;
            end
         endcase
      endfunction

      task flag_mismatch(string msg);
         $display("%0t mismatch: %s", $time, msg);
         errors++;
      endtask

      task match_frame(sdf_pkg::frame_type got);
         sdf_pkg::frame_type want;
         if (pending_frames.size() == 0) begin
            flag_mismatch($sformatf("frame %0d arrived with none expected", frames_seen));
         end else begin
            want = pending_frames.pop_front();
            for (int j = 0; j < sdf_pkg::STORE_DEPTH; j++)
               if (got[j] !== want[j])
                  flag_mismatch($sformatf("frame %0d word_%0d got %h want %h",
                                          frames_seen, j, got[j], want[j]));
         end
         frames_seen++;
      endtask
   endclass

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   logic [15:0] rsp_word_0, rsp_word_1, rsp_word_2, rsp_word_3;
   logic [15:0] rsp_word_4, rsp_word_5, rsp_word_6, rsp_word_7;
   logic        csr_valid     = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_sync_byte = 8'h00;

   gap_mode_type      mode = GAP_NONE;
   frame_tracker      tracker;
   sdf_pkg::byte_type burst [$];

   sync_word_frame_deframer u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_rx_byte   (req_rx_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_word_0    (rsp_word_0),
      .rsp_word_1    (rsp_word_1),
      .rsp_word_2    (rsp_word_2),
      .rsp_word_3    (rsp_word_3),
      .rsp_word_4    (rsp_word_4),
      .rsp_word_5    (rsp_word_5),
      .rsp_word_6    (rsp_word_6),
      .rsp_word_7    (rsp_word_7),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_sync_byte (csr_sync_byte)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic sdf_pkg::byte_type data_high(sdf_pkg::byte_type s);
      sdf_pkg::byte_type v;
      int                r;
      r = $urandom_range(0, 9);
      v = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF :
          sdf_pkg::byte_type'($urandom_range(0, 255));
      if (v == s) v = v ^ 8'h01;
      return v;
   endfunction

   function automatic sdf_pkg::byte_type data_low(sdf_pkg::byte_type s);
      if ($urandom_range(0, 4) == 0) return s;
      return sdf_pkg::byte_type'($urandom_range(0, 255));
   endfunction

   function automatic sdf_pkg::byte_type stray(sdf_pkg::byte_type s);
      sdf_pkg::byte_type v;
      v = sdf_pkg::byte_type'($urandom_range(0, 255));
      if (v == s) v = v ^ 8'h80;
      return v;
   endfunction

   // mostly whole frames; some cut short by a resync, broken hunts, raw noise
   task build_burst(sdf_pkg::byte_type s);
      int kind;
      int n;
      int k;
      burst.delete();
      kind = $urandom_range(0, 99);
      if (kind < 82) begin
         n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
         repeat (n) burst.push_back(stray(s));
         n = ($urandom_range(0, 4) == 0) ? $urandom_range(3, 4) : 2;
         repeat (n) burst.push_back(s);
         k = (kind < 70) ? sdf_pkg::WORDS_PER_FRAME :
             $urandom_range(1, sdf_pkg::WORDS_PER_FRAME - 1);
         repeat (k) begin
            burst.push_back(data_high(s));
            burst.push_back(data_low(s));
         end
         if (kind >= 70) burst.push_back(s);
      end else if (kind < 90) begin
         burst.push_back(s);
         burst.push_back(stray(s));
      end else begin
         n = $urandom_range(1, 6);
         repeat (n) burst.push_back(sdf_pkg::byte_type'($urandom_range(0, 255)));
      end
   endtask

   task send_byte(sdf_pkg::byte_type b);
      int pct;
      pct = (mode == GAP_SEND) ? 57 : (mode == GAP_BOTH) ? 15 : 0;
      if ($urandom_range(0, 99) < pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < pct);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      tracker.take_byte(b);
   endtask

   task write_sync(sdf_pkg::byte_type v);
      csr_valid     <= 1'b1;
      csr_sync_byte <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      tracker.set_sync(v);
   endtask

   // drop valid, let owed frames arrive, then give the parser time to go quiet
   task settle();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      sdf_pkg::frame_type got;
      int                 pct;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got[0] = rsp_word_0;
            got[1] = rsp_word_1;
            got[2] = rsp_word_2;
            got[3] = rsp_word_3;
            got[4] = rsp_word_4;
            got[5] = rsp_word_5;
            got[6] = rsp_word_6;
            got[7] = rsp_word_7;
            tracker.match_frame(got);
         end
         pct = (mode == GAP_RECV) ? 57 : (mode == GAP_BOTH) ? 15 : 0;
         rsp_ready <= ($urandom_range(0, 99) >= pct);
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("watchdog: %0d cycles without a transaction", quiet);
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      sdf_pkg::byte_type directed [$];
      sdf_pkg::byte_type s;
      int                sent;
      tracker = new();
      tracker.clear();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_sync(sdf_pkg::SYNC_RESET);
      // hunt restart, extra syncs, resync at a high byte, then a full frame
      directed = '{8'h00, 8'hFF, 8'h7E, 8'hFF, 8'hFF, 8'hFF, 8'h12, 8'h34,
                   8'hFF, 8'hFF,
                   8'h00, 8'h00, 8'hFE, 8'hFF, 8'h80, 8'h01, 8'h7F, 8'h80,
                   8'h01, 8'hFE, 8'h55, 8'hAA, 8'hAA, 8'h55, 8'hFE, 8'h00};
      foreach (directed[i]) send_byte(directed[i]);
      settle();

      for (int p = 0; p < PHASES; p++) begin
         mode = gap_mode_type'(p % 4);
         case (p)
            0, 3:    s = 8'hFF;
            1, 5:    s = 8'h00;
            4:       s = 8'h7F;
            7:       s = 8'h80;
            default: s = sdf_pkg::byte_type'($urandom_range(1, 254));
         endcase
         write_sync(s);
         sent = 0;
         while (sent < PHASE_BYTES) begin
            build_burst(s);
            foreach (burst[i]) send_byte(burst[i]);
            sent += burst.size();
         end
         settle();
      end

      $display("run covered %0d bytes and %0d frames over %0d sync byte settings",
               tracker.bytes_seen, tracker.frames_seen, PHASES + 1);
      $display("pacing mixed free flow, sender gaps, receiver stalls and both at once");
      if (tracker.errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
